// File: hdl/assert_macros.svh
// assertion macros shared by the report builder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked on every clock edge outside reset
`define HKRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define HKRB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HKRB_ASSERT(lbl, prop, msg)
`define HKRB_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: hdl/hkrb_pkg.sv
// shared types and constants of the keyboard report builder
package hkrb_pkg;

  // number of held-key slots in the table
  localparam int KEY_SLOTS  = 6;
  localparam int REPORT_LEN = 5 + KEY_SLOTS;

  // widths of the slot select and the byte counter
  localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CNT_W  = ($clog2(REPORT_LEN) > 4) ? $clog2(REPORT_LEN) : 4;

  // command codes
  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_TAP     = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  // report framing bytes
  localparam logic [7:0] HDR_SYNC  = 8'hFD;
  localparam logic [7:0] HDR_LEN   = 8'((3 + KEY_SLOTS) % 256);
  localparam logic [7:0] HDR_DESC  = 8'h01;
  localparam logic [7:0] HDR_RSVD  = 8'h00;
  localparam logic [7:0] KEY_EMPTY = 8'h00;

  // byte positions within a report
  localparam logic [CNT_W-1:0] POS_SYNC = CNT_W'(0);
  localparam logic [CNT_W-1:0] POS_LEN  = CNT_W'(1);
  localparam logic [CNT_W-1:0] POS_DESC = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_MODS = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_RSVD = CNT_W'(4);
  localparam logic [CNT_W-1:0] POS_KEYS = CNT_W'(5);
  localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(REPORT_LEN - 1);

  // table update applied by the datapath
  typedef enum logic [1:0] {
    OP_PRESS,
    OP_RELEASE,
    OP_CLEAR
  } op_t;

  // input beat
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] key_code;
    logic [7:0] modifier_mask;
  } in_t;

  // output beat
  typedef struct packed {
    logic [7:0] report_byte;
    logic [3:0] byte_index;
    logic       last_byte;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic apply;
    op_t  op;
    logic use_held;
    logic emit;
    logic final_rpt;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic report_done;
  } dp_sts_t;

endpackage

// File: hdl/hkrb_dp.sv
// key table, modifier byte, report byte mux and output register
`include "assert_macros.svh"

module hkrb_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  hkrb_pkg::in_t    in_data,
  input  hkrb_pkg::dp_cmd_t cmd,
  output hkrb_pkg::dp_sts_t sts,
  output logic             out_valid,
  input  logic             out_ready,
  output hkrb_pkg::out_t   out_data
);
  import hkrb_pkg::*;

  logic [7:0]       keys_r     [KEY_SLOTS];
  logic [7:0]       keys_nxt   [KEY_SLOTS];
  logic [7:0]       mods_r;
  logic [7:0]       mods_nxt;
  logic [7:0]       code_hold_r;
  logic [7:0]       mask_hold_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  out_t             out_data_r;

  logic [7:0]         src_code;
  logic [7:0]         src_mask;
  logic [KEY_SLOTS-1:0] match_v;
  logic [KEY_SLOTS-1:0] empty_v;
  logic [KEY_SLOTS-1:0] match_oh;
  logic [KEY_SLOTS-1:0] empty_oh;
  logic               seen_m;
  logic               seen_e;
  logic               any_match;
  logic               any_empty;
  logic               load;
  logic [CNT_W-1:0]   slot_sel;
  logic [7:0]         byte_sel;

  // operands come from the input beat or from the held copy
  assign src_code = cmd.use_held ? code_hold_r : in_data.key_code;
  assign src_mask = cmd.use_held ? mask_hold_r : in_data.modifier_mask;

  // slot compare and first-hit priority select
  always_comb begin
    seen_m = 1'b0;
    seen_e = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      match_v[i]  = (keys_r[i] == src_code);
      empty_v[i]  = (keys_r[i] == KEY_EMPTY);
      match_oh[i] = match_v[i] && !seen_m;
      empty_oh[i] = empty_v[i] && !seen_e;
      seen_m      = seen_m | match_v[i];
      seen_e      = seen_e | empty_v[i];
    end
  end

  assign any_match = |match_v;
  assign any_empty = |empty_v;

  // table and modifier update
  always_comb begin
    keys_nxt = keys_r;
    mods_nxt = mods_r;
    if (cmd.apply) begin
      unique case (cmd.op)
        OP_PRESS: begin
          mods_nxt = mods_r | src_mask;
          if ((src_code != KEY_EMPTY) && !any_match) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
              if (empty_oh[i]) begin
                keys_nxt[i] = src_code;
              end
            end
          end
        end
        OP_RELEASE: begin
          mods_nxt = mods_r & ~src_mask;
          if (src_code != KEY_EMPTY) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
              if (match_oh[i]) begin
                keys_nxt[i] = KEY_EMPTY;
              end
            end
          end
        end
        OP_CLEAR: begin
          mods_nxt = 8'h00;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            keys_nxt[i] = KEY_EMPTY;
          end
        end
        default: begin
          mods_nxt = mods_r;
        end
      endcase
    end
  end

  // report byte select
  assign slot_sel = cnt_r - POS_KEYS;

  always_comb begin
    unique case (cnt_r)
      POS_SYNC: byte_sel = HDR_SYNC;
      POS_LEN:  byte_sel = HDR_LEN;
      POS_DESC: byte_sel = HDR_DESC;
      POS_MODS: byte_sel = mods_r;
      POS_RSVD: byte_sel = HDR_RSVD;
      default:  byte_sel = keys_r[slot_sel[SLOT_W-1:0]];
    endcase
  end

  // byte counter steps on each beat loaded into the output register
  assign load    = cmd.emit && (!out_valid_r || out_ready);
  assign cnt_nxt = (cnt_r == POS_LAST) ? '0 : cnt_r + CNT_W'(1);

  assign sts.report_done = load && (cnt_r == POS_LAST);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r      <= '{default: KEY_EMPTY};
      mods_r      <= 8'h00;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      keys_r <= keys_nxt;
      mods_r <= mods_nxt;
      if (load) begin
        cnt_r <= cnt_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.apply && !cmd.use_held) begin
      code_hold_r <= in_data.key_code;
      mask_hold_r <= in_data.modifier_mask;
    end
    if (load) begin
      out_data_r.report_byte <= byte_sel;
      out_data_r.byte_index  <= cnt_r[3:0];
      out_data_r.last_byte   <= cmd.final_rpt && (cnt_r == POS_LAST);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // true when the code sits in some slot
  function automatic logic is_held(input logic [7:0] code);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      hit = hit | (keys_r[i] == code);
    end
    return hit;
  endfunction

  // a press with room or a repeat leaves the key held
  `HKRB_ASSERT(a_press_held, (cmd.apply && (cmd.op == OP_PRESS) && (src_code != KEY_EMPTY) && (any_match || any_empty)) |=> is_held($past(src_code)), "pressed key not held")
  // a release leaves the key nowhere in the table
  `HKRB_ASSERT(a_release_gone, (cmd.apply && (cmd.op == OP_RELEASE) && (src_code != KEY_EMPTY)) |=> !is_held($past(src_code)), "released key still held")
  // release all empties everything
  `HKRB_ASSERT(a_clear_empty, (cmd.apply && (cmd.op == OP_CLEAR)) |=> ((mods_r == 8'h00) && (&empty_v)), "state not cleared")

endmodule

// File: hdl/hkrb_ctrl.sv
// command sequencer of the keyboard report builder
`include "assert_macros.svh"

module hkrb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  output hkrb_pkg::dp_cmd_t cmd,
  input  hkrb_pkg::dp_sts_t sts
);
  import hkrb_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   pending_r;
  logic   pending_nxt;
  logic   in_ready_r;
  logic   in_ready_nxt;
  logic   accept;
  op_t    in_op;

  assign accept = in_valid && in_ready_r;

  // map the command code to the first table update
  always_comb begin
    unique case (in_command) inside
      CMD_PRESS, CMD_TAP: in_op = OP_PRESS;
      CMD_RELEASE:        in_op = OP_RELEASE;
      default:            in_op = OP_CLEAR;
    endcase
  end

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    pending_nxt   = pending_r;
    cmd.apply     = 1'b0;
    cmd.op        = in_op;
    cmd.use_held  = 1'b0;
    cmd.emit      = 1'b0;
    cmd.final_rpt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.apply   = 1'b1;
          pending_nxt = (in_command == CMD_TAP);
          state_nxt   = ST_SEND;
        end
      end
      ST_SEND: begin
        cmd.emit      = 1'b1;
        cmd.final_rpt = !pending_r;
        if (sts.report_done) begin
          if (pending_r) begin
            // second half of press-once: release after the first report
            cmd.apply    = 1'b1;
            cmd.op       = OP_RELEASE;
            cmd.use_held = 1'b1;
            pending_nxt  = 1'b0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready_nxt = (state_nxt == ST_IDLE);

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pending_r  <= 1'b0;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pending_r  <= pending_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

  // one command in flight at a time
  `HKRB_ASSERT(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready, "beat taken while busy")
  // the final report of a command frees the input
  `HKRB_ASSERT(a_done_frees, (sts.report_done && !pending_r) |=> in_ready, "input not freed after last report")

endmodule

// File: hdl/hid_keyboard_report_builder_unit.sv
// top level of the HID boot keyboard report builder
// Keeps a six-slot held-key table and a modifier byte and answers each command beat
// with framed 11-byte reports (FD, 09, 01, mods, 00, six key slots), one byte per
// output beat. A command is accepted only while no report is in progress; its report
// leaves the output register at one byte per cycle while out_ready does not stall,
// and press-once sends two reports. The report bytes pass through a single output
// register; the last byte of a command may still wait in it while the next command
// is taken. Stalls on out_ready hold the report bytes back.
module hid_keyboard_report_builder_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hkrb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hkrb_pkg::out_t out_data
);
  import hkrb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  hkrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_data.command),
    .cmd        (cmd),
    .sts        (sts)
  );

  // table and report path
  hkrb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
